/* src/bct_pkg.sv */
package bct_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int PIN_LIMIT_DEF = 4;

    localparam int MODE_W = 2;
    localparam int BLK_W  = 32;
    localparam int PID_W  = 16;
    localparam int SLOT_W = 6;
    localparam int STAT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_PIN   = 2'd2,
        MODE_UNPIN = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_ABSENT     = 2'd1,
        ST_PIN_FULL   = 2'd2,
        ST_NOT_PINNED = 2'd3
    } t_status;

endpackage

/* src/bct_if.sv */
interface bct_in_if import bct_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_mode                mode;
    logic [BLK_W-1:0]     block_no;
    logic [PID_W-1:0]     requester_pid;

    modport source (output valid, mode, block_no, requester_pid, input ready);
    modport sink   (input valid, mode, block_no, requester_pid, output ready);
endinterface

interface bct_out_if import bct_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    t_status              status;
    logic                 writeback_valid;
    logic [BLK_W-1:0]     writeback_block;

    modport source (output valid, hit, slot, status, writeback_valid, writeback_block,
                    input ready);
    modport sink   (input valid, hit, slot, status, writeback_valid, writeback_block,
                    output ready);
endinterface

/* src/bct_ram.sv */
module bct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/block_cache_tag_table_top.sv */
// channel   dir  modport  payload
// i_in      in   sink     mode, block_no, requester_pid
// o_out     out  source   hit, slot, status, writeback_valid, writeback_block
//
// one transaction at a time: accept, hash, a read and a check per probed slot, finish;
// pin and unpin of a present block add a read and a check per owner entry walked, a
// decide step, and a read and a write per entry shifted
// the slot ram read port sets the probe cost, one slot examined per read
// after reset a clearing pass over every slot empties the slot ram; no input is taken
// a finished result waits in the output register; the next input is taken meanwhile
module block_cache_tag_table_top import bct_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int PIN_LIMIT = PIN_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bct_in_if.sink    i_in,
    bct_out_if.source o_out
);
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW  = $clog2(PIN_LIMIT + 1);
    localparam int OD  = SLOTS * PIN_LIMIT;
    localparam int OAW = (OD > 1) ? $clog2(OD) : 1;
    localparam int EW  = 2 + PW + BLK_W;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_HASH  = 11'b00000000100,
        S_PRD   = 11'b00000001000,
        S_PCHK  = 11'b00000010000,
        S_ORD   = 11'b00000100000,
        S_OCHK  = 11'b00001000000,
        S_DEC   = 11'b00010000000,
        S_SRD   = 11'b00100000000,
        S_SWR   = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [SW:0]       r_rem, n_rem;
    logic [2:0]        r_bcnt, n_bcnt;
    logic [BLK_W-1:0]  r_hsh, n_hsh;
    t_mode             r_mode, n_mode;
    logic [BLK_W-1:0]  r_bn, n_bn;
    logic [PID_W-1:0]  r_pid, n_pid;
    logic [SW-1:0]     r_idx, n_idx;
    logic [SW-1:0]     r_i, n_i;
    logic [SW-1:0]     r_clr, n_clr;
    logic              r_have_cand, n_have_cand;
    logic [SW-1:0]     r_vic_idx, n_vic_idx;
    logic              r_vic_valid, n_vic_valid;
    logic              r_vic_dirty, n_vic_dirty;
    logic [BLK_W-1:0]  r_vic_tag, n_vic_tag;
    logic [SW-1:0]     r_slot, n_slot;
    logic              r_ent_dirty, n_ent_dirty;
    logic [PW-1:0]     r_n, n_n;
    logic [PW-1:0]     r_k, n_k;
    logic              r_hit, n_hit;
    t_status           r_status, n_status;
    logic              r_cnt_we, n_cnt_we;

    logic              r_out_valid, n_out_valid;
    logic              r_o_hit, n_o_hit;
    logic [SLOT_W-1:0] r_o_slot, n_o_slot;
    t_status           r_o_status, n_o_status;
    logic              r_o_wbv, n_o_wbv;
    logic [BLK_W-1:0]  r_o_wbb, n_o_wbb;

    // slot ram: {valid, dirty, pin count, tag}
    logic              s_we;
    logic [SW-1:0]     s_waddr;
    logic [EW-1:0]     s_wdata, s_rdata;
    logic              e_valid, e_dirty;
    logic [PW-1:0]     e_pin, e_pin_cl;
    logic [BLK_W-1:0]  e_tag;

    // owner ram: SLOTS rows of PIN_LIMIT requester ids
    logic              o_we;
    logic [OAW-1:0]    o_waddr, o_raddr, o_base;
    logic [PID_W-1:0]  o_wdata, o_rdata;

    logic [SW:0]       idx_inc;
    logic [PW:0]       k_inc, k_inc2;
    logic [SW:0]       h_rem;
    logic              is_access;

    bct_ram #(.WIDTH(EW), .DEPTH(SLOTS), .AW(SW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (r_idx),
        .o_rdata (s_rdata)
    );

    bct_ram #(.WIDTH(PID_W), .DEPTH(OD), .AW(OAW)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (o_we),
        .i_waddr (o_waddr),
        .i_wdata (o_wdata),
        .i_raddr (o_raddr),
        .o_rdata (o_rdata)
    );

    assign {e_valid, e_dirty, e_pin, e_tag} = s_rdata;
    assign e_pin_cl  = (e_pin > PW'(PIN_LIMIT)) ? PW'(PIN_LIMIT) : e_pin;
    assign o_base    = OAW'(r_slot) * OAW'(PIN_LIMIT);
    assign idx_inc   = {1'b0, r_idx} + 1'b1;
    assign k_inc     = {1'b0, r_k} + 1'b1;
    assign k_inc2    = {1'b0, r_k} + 2'd2;
    assign is_access = (r_mode == MODE_READ) || (r_mode == MODE_WRITE);
    assign o_raddr   = (r_state == S_SRD) ? o_base + OAW'(k_inc) : o_base + OAW'(r_k);

    // modulo by SLOTS, four bits of the block number per cycle, msb first
    always_comb begin
        h_rem = r_rem;
        for (int b = 0; b < 4; b++) begin
            h_rem = {h_rem[SW-1:0], r_hsh[BLK_W-1-b]};
            if (h_rem >= (SW+1)'(SLOTS)) begin
                h_rem = h_rem - (SW+1)'(SLOTS);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_bcnt      = r_bcnt;
        n_hsh       = r_hsh;
        n_mode      = r_mode;
        n_bn        = r_bn;
        n_pid       = r_pid;
        n_idx       = r_idx;
        n_i         = r_i;
        n_clr       = r_clr;
        n_have_cand = r_have_cand;
        n_vic_idx   = r_vic_idx;
        n_vic_valid = r_vic_valid;
        n_vic_dirty = r_vic_dirty;
        n_vic_tag   = r_vic_tag;
        n_slot      = r_slot;
        n_ent_dirty = r_ent_dirty;
        n_n         = r_n;
        n_k         = r_k;
        n_hit       = r_hit;
        n_status    = r_status;
        n_cnt_we    = r_cnt_we;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_hit     = r_o_hit;
        n_o_slot    = r_o_slot;
        n_o_status  = r_o_status;
        n_o_wbv     = r_o_wbv;
        n_o_wbb     = r_o_wbb;
        s_we        = 1'b0;
        s_waddr     = r_slot;
        s_wdata     = {1'b1, r_ent_dirty, r_n, r_bn};
        o_we        = 1'b0;
        o_waddr     = o_base + OAW'(r_k);
        o_wdata     = o_rdata;

        unique case (r_state)
            S_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_clr;
                s_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode      = i_in.mode;
                    n_bn        = i_in.block_no;
                    n_pid       = i_in.requester_pid;
                    n_hsh       = i_in.block_no;
                    n_rem       = '0;
                    n_bcnt      = '0;
                    n_hit       = 1'b0;
                    n_status    = ST_OK;
                    n_cnt_we    = 1'b0;
                    n_have_cand = 1'b0;
                    n_state     = S_HASH;
                end
            end
            S_HASH: begin
                n_rem  = h_rem;
                n_hsh  = {r_hsh[BLK_W-5:0], 4'b0};
                n_bcnt = r_bcnt + 1'b1;
                if (r_bcnt == 3'd7) begin
                    n_idx   = h_rem[SW-1:0];
                    n_i     = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (r_i == '0) begin
                    // home slot is the victim unless a later candidate turns up
                    n_vic_idx   = r_idx;
                    n_vic_valid = e_valid;
                    n_vic_dirty = e_dirty;
                    n_vic_tag   = e_tag;
                end
                if (e_valid && e_tag == r_bn) begin
                    n_hit       = 1'b1;
                    n_slot      = r_idx;
                    n_ent_dirty = e_dirty;
                    n_n         = e_pin_cl;
                    n_k         = '0;
                    if (is_access) begin
                        n_state = S_FIN;
                    end else if (e_pin_cl == '0) begin
                        n_state = S_DEC;
                    end else begin
                        n_state = S_ORD;
                    end
                end else if (!e_valid) begin
                    if (r_i != '0 && !r_have_cand) begin
                        n_vic_idx   = r_idx;
                        n_vic_valid = 1'b0;
                        n_vic_dirty = 1'b0;
                        n_vic_tag   = e_tag;
                    end
                    if (!is_access) begin
                        n_status = ST_ABSENT;
                    end
                    n_state = S_FIN;
                end else begin
                    if (r_i != '0 && !r_have_cand && e_pin == '0) begin
                        n_have_cand = 1'b1;
                        n_vic_idx   = r_idx;
                        n_vic_valid = 1'b1;
                        n_vic_dirty = e_dirty;
                        n_vic_tag   = e_tag;
                    end
                    if (r_i == SW'(SLOTS - 1)) begin
                        if (!is_access) begin
                            n_status = ST_ABSENT;
                        end
                        n_state = S_FIN;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_idx   = (idx_inc == (SW+1)'(SLOTS)) ? '0 : idx_inc[SW-1:0];
                        n_state = S_PRD;
                    end
                end
            end
            S_ORD: begin
                n_state = S_OCHK;
            end
            S_OCHK: begin
                if (o_rdata == r_pid) begin
                    n_state = S_DEC;
                end else begin
                    n_k = k_inc[PW-1:0];
                    if (k_inc == {1'b0, r_n}) begin
                        n_state = S_DEC;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            S_DEC: begin
                n_state = S_FIN;
                if (r_mode == MODE_PIN) begin
                    if (r_n >= PW'(PIN_LIMIT)) begin
                        n_status = ST_PIN_FULL;
                    end else if (r_k == r_n) begin
                        o_we     = 1'b1;
                        o_waddr  = o_base + OAW'(r_n);
                        o_wdata  = r_pid;
                        n_n      = r_n + 1'b1;
                        n_cnt_we = 1'b1;
                    end
                end else if (r_n != '0) begin
                    if (r_k == r_n) begin
                        n_status = ST_NOT_PINNED;
                    end else if (k_inc < {1'b0, r_n}) begin
                        n_state = S_SRD;
                    end else begin
                        n_n      = r_n - 1'b1;
                        n_cnt_we = 1'b1;
                    end
                end
            end
            S_SRD: begin
                n_state = S_SWR;
            end
            S_SWR: begin
                // close the gap left by the removed owner
                o_we = 1'b1;
                n_k  = k_inc[PW-1:0];
                if (k_inc2 < {1'b0, r_n}) begin
                    n_state = S_SRD;
                end else begin
                    n_n      = r_n - 1'b1;
                    n_cnt_we = 1'b1;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_hit     = r_hit;
                    n_o_status  = r_status;
                    n_o_wbv     = 1'b0;
                    n_o_wbb     = '0;
                    n_o_slot    = r_hit ? SLOT_W'(r_slot) : '0;
                    if (is_access && r_hit) begin
                        s_we    = 1'b1;
                        s_wdata = {1'b1, r_ent_dirty || (r_mode == MODE_WRITE), r_n, r_bn};
                    end else if (is_access) begin
                        s_we     = 1'b1;
                        s_waddr  = r_vic_idx;
                        s_wdata  = {1'b1, r_mode == MODE_WRITE, PW'(0), r_bn};
                        n_o_slot = SLOT_W'(r_vic_idx);
                        n_o_wbv  = r_vic_valid && r_vic_dirty;
                        n_o_wbb  = (r_vic_valid && r_vic_dirty) ? r_vic_tag : '0;
                    end else if (r_cnt_we) begin
                        s_we = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_bcnt      <= n_bcnt;
        r_hsh       <= n_hsh;
        r_mode      <= n_mode;
        r_bn        <= n_bn;
        r_pid       <= n_pid;
        r_idx       <= n_idx;
        r_i         <= n_i;
        r_have_cand <= n_have_cand;
        r_vic_idx   <= n_vic_idx;
        r_vic_valid <= n_vic_valid;
        r_vic_dirty <= n_vic_dirty;
        r_vic_tag   <= n_vic_tag;
        r_slot      <= n_slot;
        r_ent_dirty <= n_ent_dirty;
        r_n         <= n_n;
        r_k         <= n_k;
        r_hit       <= n_hit;
        r_status    <= n_status;
        r_cnt_we    <= n_cnt_we;
        r_o_hit     <= n_o_hit;
        r_o_slot    <= n_o_slot;
        r_o_status  <= n_o_status;
        r_o_wbv     <= n_o_wbv;
        r_o_wbb     <= n_o_wbb;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.hit             = r_o_hit;
    assign o_out.slot            = r_o_slot;
    assign o_out.status          = r_o_status;
    assign o_out.writeback_valid = r_o_wbv;
    assign o_out.writeback_block = r_o_wbb;
endmodule

/* verif/block_cache_tag_table_checker.sv */
module block_cache_tag_table_checker import bct_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int PIN_LIMIT = PIN_LIMIT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bct_in_if.sink    i_in_mon,
    bct_out_if.sink   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        t_status           status;
        logic              wb_valid;
        logic [BLK_W-1:0]  wb_block;
    } t_lookup;

    logic              tbl_valid [SLOTS];
    logic [BLK_W-1:0]  tbl_tag   [SLOTS];
    logic              tbl_dirty [SLOTS];
    int                tbl_pins  [SLOTS];
    logic [PID_W-1:0]  tbl_owner [SLOTS][PIN_LIMIT];

    t_lookup expected_lookups[$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_lookups.size();

    function automatic int locate(input logic [BLK_W-1:0] blk);
        int home;
        int idx;
        home = blk % SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
            idx = (home + i) % SLOTS;
            if (!tbl_valid[idx]) return -1;
            if (tbl_tag[idx] == blk) return idx;
        end
        return -1;
    endfunction

    function automatic t_lookup apply_access(input t_mode m, input logic [BLK_W-1:0] blk,
                                             input logic [PID_W-1:0] pid);
        t_lookup r;
        int found;
        int home;
        int tgt;
        int idx;
        int n;
        int k;
        r = '0;
        r.status = ST_OK;
        found = locate(blk);
        if (m == MODE_READ || m == MODE_WRITE) begin
            if (found >= 0) begin
                r.hit  = 1'b1;
                r.slot = found[SLOT_W-1:0];
                if (m == MODE_WRITE) tbl_dirty[found] = 1'b1;
            end else begin
                home = blk % SLOTS;
                tgt  = home;
                if (tbl_valid[home]) begin
                    for (int i = 1; i < SLOTS; i++) begin
                        idx = (home + i) % SLOTS;
                        if (!tbl_valid[idx] || tbl_pins[idx] == 0) begin
                            tgt = idx;
                            break;
                        end
                    end
                    if (tbl_valid[tgt] && tbl_dirty[tgt]) begin
                        r.wb_valid = 1'b1;
                        r.wb_block = tbl_tag[tgt];
                    end
                end
                tbl_valid[tgt] = 1'b1;
                tbl_tag[tgt]   = blk;
                tbl_dirty[tgt] = (m == MODE_WRITE);
                tbl_pins[tgt]  = 0;
                r.slot = tgt[SLOT_W-1:0];
            end
        end else if (found < 0) begin
            r.status = ST_ABSENT;
        end else begin
            n = tbl_pins[found];
            r.hit  = 1'b1;
            r.slot = found[SLOT_W-1:0];
            k = 0;
            while (k < n && tbl_owner[found][k] != pid) k++;
            if (m == MODE_PIN) begin
                if (n >= PIN_LIMIT) r.status = ST_PIN_FULL;
                else if (k == n) begin
                    tbl_owner[found][n] = pid;
                    tbl_pins[found] = n + 1;
                end
            end else if (n != 0) begin
                if (k == n) r.status = ST_NOT_PINNED;
                else begin
                    for (; k + 1 < n; k++) tbl_owner[found][k] = tbl_owner[found][k+1];
                    tbl_pins[found] = n - 1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup want;
        t_lookup got;
        if (!i_rst_n) begin
            fails = 0;
            expected_lookups.delete();
            for (int s = 0; s < SLOTS; s++) begin
                tbl_valid[s] = 1'b0;
                tbl_dirty[s] = 1'b0;
                tbl_pins[s]  = 0;
            end
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                expected_lookups.push_back(apply_access(i_in_mon.mode, i_in_mon.block_no,
                                                        i_in_mon.requester_pid));
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.hit      = i_out_mon.hit;
                got.slot     = i_out_mon.slot;
                got.status   = i_out_mon.status;
                got.wb_valid = i_out_mon.writeback_valid;
                got.wb_block = i_out_mon.writeback_block;
                if (expected_lookups.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result transaction %p", got);
                end else begin
                    want = expected_lookups.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
    end
endmodule

/* verif/block_cache_tag_table_top_tb.sv */
module block_cache_tag_table_top_tb;
    import bct_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;   // chance of a gap on the input side
    int   recv_stall_pct = 0;  // chance of a stall on the output side
    bit   hold_off = 1'b0;     // long receiver stall while the sender keeps going
    logic [BLK_W-1:0] hot_blocks[16];  // small working set so hits and evictions happen

    bct_in_if  in_ch ();
    bct_out_if out_ch ();

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    block_cache_tag_table_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    block_cache_tag_table_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch.sink),
        .i_out_mon   (out_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // output side: random stalls, and a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one transaction and wait for its acceptance, with optional idle gap first
    task automatic send_access(input t_mode m, input logic [BLK_W-1:0] blk,
                               input logic [PID_W-1:0] pid);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= m;
        in_ch.block_no      <= blk;
        in_ch.requester_pid <= pid;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random(input int n);
        t_mode m;
        logic [BLK_W-1:0] blk;
        for (int i = 0; i < n; i++) begin
            m = t_mode'($urandom_range(3));
            case ($urandom_range(9))
                0: blk = $urandom();
                1: blk = {2'($urandom_range(3)), 24'd0, 6'($urandom_range(3))};
                default: blk = hot_blocks[$urandom_range(15)];
            endcase
            send_access(m, blk, PID_W'($urandom_range(5)) | ($urandom_range(7) == 0 ?
                        PID_W'($urandom()) : '0));
        end
    endtask

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int guard;
        in_ch.valid         = 1'b0;
        in_ch.mode          = MODE_READ;
        in_ch.block_no      = '0;
        in_ch.requester_pid = '0;
        // several block numbers share a home slot, others are spread
        for (int i = 0; i < 16; i++)
            hot_blocks[i] = (i < 8) ? BLK_W'(i * SLOTS_DEF + 5) : BLK_W'($urandom());
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every mode and the pin list corner cases
        send_access(MODE_PIN,   32'd0,          16'd0);      // pin of absent block
        send_access(MODE_WRITE, 32'hFFFF_FFFF,  16'hFFFF);
        send_access(MODE_READ,  32'd0,          16'd0);
        send_access(MODE_READ,  32'hFFFF_FFFF,  16'd0);      // hit
        send_access(MODE_UNPIN, 32'd0,          16'd1);      // unpin on empty list
        send_access(MODE_PIN,   32'd0,          16'h5555);
        send_access(MODE_PIN,   32'd0,          16'h5555);   // already listed
        send_access(MODE_PIN,   32'd0,          16'hAAAA);
        send_access(MODE_PIN,   32'd0,          16'hFFFF);
        send_access(MODE_PIN,   32'd0,          16'd7);
        send_access(MODE_PIN,   32'd0,          16'd8);      // limit reached
        send_access(MODE_PIN,   32'd0,          16'h5555);   // limit, even if listed
        send_access(MODE_UNPIN, 32'd0,          16'd9);      // not listed
        send_access(MODE_UNPIN, 32'd0,          16'hAAAA);   // shift the list
        send_access(MODE_WRITE, 32'd64,         16'd0);      // collides with block 0
        send_access(MODE_WRITE, 32'd128,        16'd0);
        send_access(MODE_READ,  32'd128,        16'd0);
        send_access(MODE_UNPIN, 32'h8000_0000,  16'd0);
        send_access(MODE_WRITE, 32'hAAAA_AAAA,  16'd0);
        send_access(MODE_WRITE, 32'h5555_5555,  16'd0);

        // random phases with different idling
        send_random(400);
        send_idle_pct = 52;
        send_random(350);
        send_idle_pct = 0;
        recv_stall_pct = 52;
        send_random(350);
        send_idle_pct = 35;
        recv_stall_pct = 35;
        send_random(350);

        // long hold-off: the block fills up and stalls its input
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(20);
        join
        send_random(460);
        in_ch.valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (pending == 0 && fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
